>>> rtl/core/th_sensor_frame_decoder_core_assert.svh
// Assertion macros for the sensor frame decoder core.
// Used by the top level only; needs a clock and an active-low reset name per use.
`ifndef TH_SENSOR_FRAME_DECODER_CORE_ASSERT_SVH
`define TH_SENSOR_FRAME_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define THFD_ASSERT_IMP(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |-> (rhs)) \
        else $error("thfd assertion failed");

// next-cycle implication
`define THFD_ASSERT_NXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |=> (rhs)) \
        else $error("thfd assertion failed");

`endif

>>> rtl/core/thfd_pkg.sv
// Shared types, constants and the CRC-8 function of the sensor frame decoder.
// No dependencies.
`timescale 1ns / 1ps

package thfd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    typedef struct packed {
        logic        done;
        logic [15:0] raw_t;
        logic [15:0] raw_h;
        logic        t_ok;
        logic        h_ok;
    } frame_evt_t;

    typedef struct packed {
        logic stg_valid;
        logic can_load;
    } scale_status_t;

    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/core/thfd_frame.sv
// Byte assembly and per-word CRC-8 check of the six-byte reply.
// Depends on thfd_pkg.
`timescale 1ns / 1ps

module thfd_frame (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   fire,
    input  logic [7:0]             rx_byte,
    input  logic                   frame_start,
    output thfd_pkg::frame_evt_t   evt
);

    logic [2:0]  byte_position_reg, byte_position_next;
    logic [7:0]  running_crc_reg, running_crc_next;
    logic [15:0] raw_t_reg, raw_t_next;
    logic [15:0] raw_h_reg, raw_h_next;
    logic        t_ok_reg, t_ok_next;
    logic [2:0]  pos;
    logic [7:0]  crc_base;
    logic [7:0]  crc_fed;

    always_comb begin
        pos = frame_start ? thfd_pkg::POS_T_MSB : byte_position_reg;
        if (pos > thfd_pkg::POS_H_CRC) begin
            pos = thfd_pkg::POS_T_MSB;
        end
        crc_base = frame_start ? thfd_pkg::CRC_INIT : running_crc_reg;
        crc_fed  = thfd_pkg::crc8_feed(crc_base, rx_byte);

        byte_position_next = byte_position_reg;
        running_crc_next   = running_crc_reg;
        raw_t_next         = raw_t_reg;
        raw_h_next         = raw_h_reg;
        t_ok_next          = t_ok_reg;
        evt.done           = 1'b0;

        if (fire) begin
            byte_position_next = pos + 3'd1;
            case (pos)
                thfd_pkg::POS_T_MSB: begin
                    raw_t_next       = {rx_byte, raw_t_reg[7:0]};
                    running_crc_next = crc_fed;
                end
                thfd_pkg::POS_T_LSB: begin
                    raw_t_next       = {raw_t_reg[15:8], rx_byte};
                    running_crc_next = crc_fed;
                end
                thfd_pkg::POS_T_CRC: begin
                    t_ok_next        = (crc_base == rx_byte);
                    running_crc_next = thfd_pkg::CRC_INIT;
                end
                thfd_pkg::POS_H_MSB: begin
                    raw_h_next       = {rx_byte, raw_h_reg[7:0]};
                    running_crc_next = crc_fed;
                end
                thfd_pkg::POS_H_LSB: begin
                    raw_h_next       = {raw_h_reg[15:8], rx_byte};
                    running_crc_next = crc_fed;
                end
                default: begin
                    evt.done           = 1'b1;
                    running_crc_next   = thfd_pkg::CRC_INIT;
                    byte_position_next = thfd_pkg::POS_T_MSB;
                end
            endcase
        end

        evt.raw_t = raw_t_reg;
        evt.raw_h = raw_h_reg;
        evt.t_ok  = t_ok_reg;
        evt.h_ok  = (crc_base == rx_byte);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg <= thfd_pkg::POS_T_MSB;
            running_crc_reg   <= thfd_pkg::CRC_INIT;
            raw_t_reg         <= 16'd0;
            raw_h_reg         <= 16'd0;
            t_ok_reg          <= 1'b0;
        end else begin
            byte_position_reg <= byte_position_next;
            running_crc_reg   <= running_crc_next;
            raw_t_reg         <= raw_t_next;
            raw_h_reg         <= raw_h_next;
            t_ok_reg          <= t_ok_next;
        end
    end

endmodule

>>> rtl/core/thfd_scale.sv
// Scaling of the raw words into centi-units and the result output register.
// Depends on thfd_pkg; fed by thfd_frame.
`timescale 1ns / 1ps

module thfd_scale (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  thfd_pkg::frame_evt_t      evt,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic [31:0]               m_tdata,
    output thfd_pkg::scale_status_t   status
);

    logic        stg_valid_reg, stg_valid_next;
    logic [30:0] prod_t_reg;
    logic [29:0] prod_h_reg;
    logic        t_ok_reg;
    logic        h_ok_reg;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg;
    logic        out_adv;
    logic [16:0] rem_t;
    logic [16:0] rem_h;
    logic [15:0] temp_full;
    logic [13:0] hum_q;

    assign out_adv = !m_valid_reg || m_tready;

    always_comb begin
        stg_valid_next = stg_valid_reg;
        if (evt.done) begin
            stg_valid_next = 1'b1;
        end else if (out_adv) begin
            stg_valid_next = 1'b0;
        end
        m_valid_next = out_adv ? stg_valid_reg : m_valid_reg;

        // x / 65535 with x = a*65536 + b: quotient a, plus one when a + b >= 65535
        rem_t = {2'b00, prod_t_reg[30:16]} + {1'b0, prod_t_reg[15:0]};
        rem_h = {3'b000, prod_h_reg[29:16]} + {1'b0, prod_h_reg[15:0]};
        temp_full = {1'b0, prod_t_reg[30:16]}
                  + {15'd0, (rem_t >= thfd_pkg::FULL_SCALE)}
                  - thfd_pkg::TEMP_OFFSET;
        hum_q = prod_h_reg[29:16] + {13'd0, (rem_h >= thfd_pkg::FULL_SCALE)};
    end

    always_ff @(posedge aclk) begin
        if (evt.done) begin
            prod_t_reg <= {15'd0, evt.raw_t} * {16'd0, thfd_pkg::TEMP_SCALE};
            prod_h_reg <= {14'd0, evt.raw_h} * {16'd0, thfd_pkg::HUM_SCALE};
            t_ok_reg   <= evt.t_ok;
            h_ok_reg   <= evt.h_ok;
        end
        if (out_adv && stg_valid_reg) begin
            m_data_reg <= {1'b0, h_ok_reg, t_ok_reg, hum_q, temp_full[14:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            stg_valid_reg <= stg_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign m_tvalid         = m_valid_reg;
    assign m_tdata          = m_data_reg;
    assign status.stg_valid = stg_valid_reg;
    assign status.can_load  = !stg_valid_reg || out_adv;

endmodule

>>> rtl/core/th_sensor_frame_decoder_core.sv
// Top level of the humidity/temperature sensor frame decoder core.
// Depends on thfd_pkg, thfd_frame, thfd_scale and th_sensor_frame_decoder_core_assert.svh.
//
// Takes the six-byte sensor reply one byte per transfer (temperature MSB, LSB, CRC,
// humidity MSB, LSB, CRC) and, after the sixth byte, emits one result transfer with
// temperature in hundredths of a degree C, humidity in hundredths of a percent and a
// CRC-8 pass flag per word. s_tuser high marks a byte as the first of a reply and
// drops any partial reply. One byte is accepted per clock while s_tready is high; a result
// passes through a product register, then the output register that applies the exact
// divide by 65535. s_tready drops only while both the product stage and the output
// register hold results that the sink has not taken.
`timescale 1ns / 1ps

`include "th_sensor_frame_decoder_core_assert.svh"

module th_sensor_frame_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [14:0] temperature_centi, [28:15] humidity_centi,
                                   // [29] temperature_crc_ok, [30] humidity_crc_ok, [31] 0
);

    logic                     fire;
    thfd_pkg::frame_evt_t     evt;
    thfd_pkg::scale_status_t  status;

    assign s_tready = status.can_load;
    assign fire     = s_tvalid && s_tready;

    thfd_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser),
        .evt         (evt)
    );

    thfd_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .evt      (evt),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .status   (status)
    );

    `THFD_ASSERT_NXT(a_done_loads_stage, aclk, aresetn, evt.done, status.stg_valid)
    `THFD_ASSERT_IMP(a_stall_only_when_full, aclk, aresetn, !s_tready, m_tvalid && !m_tready)
    `THFD_ASSERT_IMP(a_rose_from_stage, aclk, aresetn, $rose(m_tvalid), $past(status.stg_valid))
    `THFD_ASSERT_IMP(a_hum_in_range, aclk, aresetn, m_tvalid, m_tdata[28:15] <= 14'd10000)

endmodule

>>> verif/th_sensor_frame_decoder_core_tb.sv
// Self-checking testbench for th_sensor_frame_decoder_core: feeds six-byte sensor
// replies, noise and cut-off replies, and checks every decoded reading.
// Depends on thfd_pkg and the core; expected readings come from a decoder kept here.
`timescale 1ns / 1ps

module th_sensor_frame_decoder_core_tb;

    typedef struct {
        logic [7:0] rx;
        logic       first;
        logic       drain;
    } rx_item_t;

    typedef struct {
        logic signed [14:0] temp;
        logic [13:0]        hum;
        logic               t_ok;
        logic               h_ok;
    } reading_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    rx_item_t byte_queue[$];
    reading_t readings_due[$];
    int       fail_count = 0;
    int       items_made = 0;
    bit       drain_next = 1'b0;

    // decoder state mirrored from the block
    logic [2:0]  dec_pos = 3'd0;
    logic [7:0]  dec_crc = thfd_pkg::CRC_INIT;
    logic [15:0] dec_raw_t = 16'h0000;
    logic [15:0] dec_raw_h = 16'h0000;
    logic        dec_t_pass = 1'b0;

    th_sensor_frame_decoder_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] crc_shift(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[7] ^ data[k];
            r = {r[6:0], 1'b0} ^ (fb ? thfd_pkg::CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return crc_shift(crc_shift(thfd_pkg::CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    task automatic decode_reply_byte(input logic [7:0] b, input logic first);
        logic [2:0]      pos;
        longint unsigned tq;
        longint unsigned hq;
        reading_t        rd;
        if (first) begin
            dec_pos = 3'd0;
            dec_crc = thfd_pkg::CRC_INIT;
        end
        pos = (dec_pos > thfd_pkg::POS_H_CRC) ? thfd_pkg::POS_T_MSB : dec_pos;
        case (pos)
            thfd_pkg::POS_T_MSB: begin
                dec_raw_t[15:8] = b;
                dec_crc = crc_shift(dec_crc, b);
            end
            thfd_pkg::POS_T_LSB: begin
                dec_raw_t[7:0] = b;
                dec_crc = crc_shift(dec_crc, b);
            end
            thfd_pkg::POS_T_CRC: begin
                dec_t_pass = (dec_crc == b);
                dec_crc = thfd_pkg::CRC_INIT;
            end
            thfd_pkg::POS_H_MSB: begin
                dec_raw_h[15:8] = b;
                dec_crc = crc_shift(dec_crc, b);
            end
            thfd_pkg::POS_H_LSB: begin
                dec_raw_h[7:0] = b;
                dec_crc = crc_shift(dec_crc, b);
            end
            default: begin
                tq = (64'd17500 * dec_raw_t) / 64'd65535;
                hq = (64'd10000 * dec_raw_h) / 64'd65535;
                rd.temp = 15'(tq - 64'd4500);
                rd.hum  = 14'(hq);
                rd.t_ok = dec_t_pass;
                rd.h_ok = (dec_crc == b);
                readings_due.push_back(rd);
                dec_crc = thfd_pkg::CRC_INIT;
            end
        endcase
        dec_pos = (pos == thfd_pkg::POS_H_CRC) ? thfd_pkg::POS_T_MSB : pos + 3'd1;
    endtask

    task automatic add_byte(input logic [7:0] b, input logic first);
        rx_item_t it;
        it.rx = b;
        it.first = first;
        it.drain = drain_next;
        drain_next = 1'b0;
        byte_queue.push_back(it);
        items_made++;
    endtask

    task automatic add_reply(input logic [15:0] t, input logic [15:0] h, input logic first,
                             input bit t_bad, input bit h_bad, input int len);
        logic [7:0] bytes[6];
        bytes[0] = t[15:8];
        bytes[1] = t[7:0];
        bytes[2] = word_crc(t) ^ (t_bad ? 8'($urandom_range(1, 255)) : 8'h00);
        bytes[3] = h[15:8];
        bytes[4] = h[7:0];
        bytes[5] = word_crc(h) ^ (h_bad ? 8'($urandom_range(1, 255)) : 8'h00);
        for (int i = 0; i < len; i++) begin
            add_byte(bytes[i], (i == 0) ? first : 1'b0);
        end
    endtask

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // source side
    always @(posedge aclk) begin : drive_proc
        rx_item_t it;
        int       gap_left;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tuser  <= 1'b0;
            gap_left = 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                decode_reply_byte(s_tdata, s_tuser);
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (byte_queue.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (byte_queue[0].drain && readings_due.size() != 0) begin
                s_tvalid <= 1'b0;
            end else if (byte_queue.size() > 150 && $urandom_range(0, 19) == 0) begin
                gap_left = $urandom_range(1, 16) - 1;
                s_tvalid <= 1'b0;
            end else begin
                it = byte_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= it.rx;
                s_tuser  <= it.first;
            end
        end
    end

    // result side
    always @(posedge aclk) begin : sink_proc
        reading_t exp_rd;
        int       stall_left;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (readings_due.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none got %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    exp_rd = readings_due.pop_front();
                    if ($signed(m_tdata[14:0]) != exp_rd.temp) begin
                        $display("%0t: temperature_centi expected %0d got %0d", $time,
                                 exp_rd.temp, $signed(m_tdata[14:0]));
                        fail_count++;
                    end
                    if (m_tdata[28:15] != exp_rd.hum) begin
                        $display("%0t: humidity_centi expected %0d got %0d", $time,
                                 exp_rd.hum, m_tdata[28:15]);
                        fail_count++;
                    end
                    if (m_tdata[29] != exp_rd.t_ok) begin
                        $display("%0t: temperature_crc_ok expected %0b got %0b", $time,
                                 exp_rd.t_ok, m_tdata[29]);
                        fail_count++;
                    end
                    if (m_tdata[30] != exp_rd.h_ok) begin
                        $display("%0t: humidity_crc_ok expected %0b got %0b", $time,
                                 exp_rd.h_ok, m_tdata[30]);
                        fail_count++;
                    end
                    if (m_tdata[31] !== 1'b0) begin
                        $display("%0t: pad bit expected 0 got %0b", $time, m_tdata[31]);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (byte_queue.size() > 150 && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("th_sensor_frame_decoder_core verification failed");
        $finish;
    end

    initial begin
        int kind;
        int len;
        // directed: extremes, bad CRCs, back-to-back, restarts mid-reply
        add_reply(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 6);
        add_reply(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0, 6);
        add_reply(16'h1234, 16'h5678, 1'b1, 1'b0, 1'b0, 4);
        add_reply(16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b1, 6);
        drain_next = 1'b1;
        while (items_made < 1250) begin
            if (items_made > 600 && items_made < 606) begin
                drain_next = 1'b1;
            end
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                add_reply(pick_raw(), pick_raw(), $urandom_range(0, 3) != 0,
                          $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0, 6);
            end else if (kind == 7) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    add_byte(8'($urandom), 1'($urandom));
                end
            end else begin
                add_reply(pick_raw(), pick_raw(), 1'b1, 1'b0, 1'b0, $urandom_range(1, 5));
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (byte_queue.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (readings_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("th_sensor_frame_decoder_core verification clean");
        end else begin
            $display("th_sensor_frame_decoder_core verification failed");
        end
        $finish;
    end

endmodule
